// ===== rtl/rfp_pkg.sv =====
`default_nettype none
package rfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned FLEN_W   = 24;
	localparam int unsigned PTYPE_W  = 7;
	localparam int unsigned SEQ_W    = 16;
	localparam int unsigned TS_W     = 32;
	localparam int unsigned REG_W    = 32;

	localparam int unsigned HDR_BYTES = 12;
	localparam int unsigned BEAT_W    = $clog2(HDR_BYTES + 1);

	// beat index of the payload byte; header beats run 0 .. HDR_BYTES-1
	localparam logic [BEAT_W-1:0] BEAT_PAYLOAD = BEAT_W'(HDR_BYTES);
	localparam logic [BEAT_W-1:0] BEAT_FIRST   = '0;

	// version 2, no padding, no extension, no csrc
	localparam logic [BYTE_W-1:0] RTP_VPXCC = 8'h80;

	localparam logic [REG_W-1:0] TS_STEP_RESET = REG_W'(90000 / 25);

	typedef enum logic [0:0] {
		REG_SOURCE_ID = 1'b0,
		REG_TS_STEP   = 1'b1
	} reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/rfp_if.sv =====
`default_nettype none
interface rfp_in_if;
	import rfp_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  data_byte;
	logic [FLEN_W-1:0]  frame_len;
	logic [PTYPE_W-1:0] payload_type;

	modport source (output valid, data_byte, frame_len, payload_type, input ready);
	modport sink   (input valid, data_byte, frame_len, payload_type, output ready);
endinterface

interface rfp_out_if;
	import rfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              packet_end;
	logic              run_last;

	modport source (output valid, out_byte, packet_end, run_last, input ready);
	modport sink   (input valid, out_byte, packet_end, run_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtp_frame_packetizer_core.sv =====
`default_nettype none
// channel   dir  payload                                    note
// frame     in   data_byte, frame_len, payload_type         one beat per frame byte
// packet    out  out_byte, packet_end, run_last             1 or 13 beats per frame byte
// cfg       in   cfg_we, cfg_index, cfg_data                write only, no wait
//
// a frame byte is taken in every cycle while packets continue and packet.ready
// is high; an opening byte waits while the one output register walks the header.
// the next byte is taken in the same cycle as the current one's last beat leaves.
// arst_n clears sequence, timestamp and frame state; source_id resets to 0 and
// timestamp_step to 3600. a stalled packet beat holds the frame channel off.
module rtp_frame_packetizer_core #(
	parameter int unsigned MAX_PAYLOAD = 1400
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	rfp_in_if.sink                         frame,
	rfp_out_if.source                      packet,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [rfp_pkg::REG_W-1:0] cfg_data
);
	import rfp_pkg::*;

	localparam int unsigned PL_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [PL_W-1:0]   PL_MAX   = PL_W'(MAX_PAYLOAD);
	localparam logic [FLEN_W-1:0] FL_LIMIT = FLEN_W'(MAX_PAYLOAD);

	// configuration
	logic [REG_W-1:0] source_id_q;
	logic [REG_W-1:0] ts_step_q;

	// packetizer state
	logic [SEQ_W-1:0]   seq_q;
	logic [TS_W-1:0]    time_q;
	logic [FLEN_W-1:0]  frame_left_q;
	logic [PL_W-1:0]    packet_left_q;
	logic [PTYPE_W-1:0] held_type_q;

	// output register
	logic               busy_q;
	logic [BEAT_W-1:0]  beat_q;
	logic [BYTE_W-1:0]  byte_s1;
	logic               pend_s1;
	logic               marker_s1;
	logic [PTYPE_W-1:0] type_s1;
	logic [SEQ_W-1:0]   seq_s1;
	logic [TS_W-1:0]    time_s1;
	logic [REG_W-1:0]   ssrc_s1;

	logic               take;
	logic               beat_go;
	logic               last_beat;
	logic               open_frame;
	logic [FLEN_W-1:0]  fl_eff;
	logic [PTYPE_W-1:0] type_eff;
	logic [PL_W-1:0]    pl_eff;
	logic               need_hdr;
	logic               marker;
	logic [PL_W-1:0]    pl_start;
	logic [PL_W-1:0]    pl_next;
	logic [FLEN_W-1:0]  fl_next;

	assign last_beat    = (beat_q == BEAT_PAYLOAD);
	assign beat_go      = busy_q && packet.ready;
	assign frame.ready  = !busy_q || (packet.ready && last_beat);
	assign take         = frame.valid && frame.ready;

	always_comb begin
		open_frame = (frame_left_q == '0);
		if (open_frame) begin
			fl_eff   = (frame.frame_len == '0) ? FLEN_W'(1) : frame.frame_len;
			type_eff = frame.payload_type;
			pl_eff   = '0;
		end else begin
			fl_eff   = frame_left_q;
			type_eff = held_type_q;
			pl_eff   = packet_left_q;
		end
		need_hdr = (pl_eff == '0);
		marker   = (fl_eff <= FL_LIMIT);
		if (need_hdr) begin
			pl_start = marker ? fl_eff[PL_W-1:0] : PL_MAX;
		end else begin
			pl_start = pl_eff;
		end
		pl_next = pl_start - PL_W'(1);
		fl_next = fl_eff - FLEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_id_q <= '0;
			ts_step_q   <= TS_STEP_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SOURCE_ID: source_id_q <= cfg_data;
				REG_TS_STEP:   ts_step_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= '0;
			time_q        <= '0;
			frame_left_q  <= '0;
			packet_left_q <= '0;
			held_type_q   <= '0;
		end else if (take) begin
			held_type_q  <= type_eff;
			frame_left_q <= fl_next;
			if (need_hdr) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
			if (fl_next == '0) begin
				// frame closes: next frame gets the stepped timestamp
				time_q        <= time_q + ts_step_q;
				packet_left_q <= '0;
			end else begin
				packet_left_q <= pl_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= BEAT_FIRST;
		end else if (take) begin
			busy_q <= 1'b1;
			beat_q <= need_hdr ? BEAT_FIRST : BEAT_PAYLOAD;
		end else if (beat_go) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1   <= frame.data_byte;
			pend_s1   <= (pl_next == '0);
			marker_s1 <= marker;
			type_s1   <= type_eff;
			seq_s1    <= seq_q;
			time_s1   <= time_q;
			ssrc_s1   <= source_id_q;
		end
	end

	always_comb begin
		case (beat_q)
			4'd0:    packet.out_byte = RTP_VPXCC;
			4'd1:    packet.out_byte = {marker_s1, type_s1};
			4'd2:    packet.out_byte = seq_s1[15:8];
			4'd3:    packet.out_byte = seq_s1[7:0];
			4'd4:    packet.out_byte = time_s1[31:24];
			4'd5:    packet.out_byte = time_s1[23:16];
			4'd6:    packet.out_byte = time_s1[15:8];
			4'd7:    packet.out_byte = time_s1[7:0];
			4'd8:    packet.out_byte = ssrc_s1[31:24];
			4'd9:    packet.out_byte = ssrc_s1[23:16];
			4'd10:   packet.out_byte = ssrc_s1[15:8];
			4'd11:   packet.out_byte = ssrc_s1[7:0];
			default: packet.out_byte = byte_s1;
		endcase
	end

	assign packet.valid      = busy_q;
	assign packet.packet_end = last_beat && pend_s1;
	assign packet.run_last   = last_beat;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
	import rfp_pkg::*;

	localparam int unsigned PAYLOAD_MAX = 1400;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned LONG_HOLD   = 400;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              packet_end;
		logic              run_last;
	} beat_t;

	class packet_scoreboard;
		beat_t             expected_q[$];
		logic [REG_W-1:0]  source_id;
		logic [REG_W-1:0]  ts_step;
		logic [SEQ_W-1:0]  seq_num;
		logic [TS_W-1:0]   frame_ts;
		logic [FLEN_W-1:0] frame_left;
		logic [10:0]       packet_left;
		logic [PTYPE_W-1:0] held_type;
		int                errors;

		function new();
			source_id   = '0;
			ts_step     = TS_STEP_RESET;
			seq_num     = '0;
			frame_ts    = '0;
			frame_left  = '0;
			packet_left = '0;
			held_type   = '0;
			errors      = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [REG_W-1:0] val);
			if (idx == REG_SOURCE_ID)
				source_id = val;
			else
				ts_step = val;
		endfunction

		// works out the packet bytes that one accepted frame byte brings out
		function void note_frame_byte(logic [BYTE_W-1:0] d, logic [FLEN_W-1:0] len,
				logic [PTYPE_W-1:0] pt);
			logic [HDR_BYTES*8-1:0] hdr;
			logic                   marker;
			if (frame_left == 0) begin
				frame_left  = (len == 0) ? FLEN_W'(1) : len;
				held_type   = pt;
				packet_left = '0;
			end
			if (packet_left == 0) begin
				marker      = (frame_left <= PAYLOAD_MAX);
				packet_left = marker ? frame_left[10:0] : 11'(PAYLOAD_MAX);
				hdr = {RTP_VPXCC, marker, held_type, seq_num, frame_ts, source_id};
				for (int i = 0; i < HDR_BYTES; i++)
					expected_q.push_back('{hdr[HDR_BYTES*8-1-8*i -: 8], 1'b0, 1'b0});
				seq_num = seq_num + 1'b1;
			end
			packet_left = packet_left - 1'b1;
			frame_left  = frame_left - 1'b1;
			expected_q.push_back('{d, packet_left == 0, 1'b1});
			if (frame_left == 0) begin
				frame_ts    = frame_ts + ts_step;
				packet_left = '0;
			end
		endfunction

		function void check_beat(logic [BYTE_W-1:0] b, logic pe, logic rl);
			beat_t exp_beat;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat out_byte=%02h packet_end=%0b run_last=%0b",
					$time, b, pe, rl);
				errors++;
				return;
			end
			exp_beat = expected_q.pop_front();
			if (b !== exp_beat.out_byte) begin
				$display("%0t: out_byte expected %02h actual %02h",
					$time, exp_beat.out_byte, b);
				errors++;
			end
			if (pe !== exp_beat.packet_end) begin
				$display("%0t: packet_end expected %0b actual %0b",
					$time, exp_beat.packet_end, pe);
				errors++;
			end
			if (rl !== exp_beat.run_last) begin
				$display("%0t: run_last expected %0b actual %0b",
					$time, exp_beat.run_last, rl);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [REG_W-1:0]  cfg_data;

	rfp_in_if  frame_ch ();
	rfp_out_if packet_ch ();

	rtp_frame_packetizer_core #(
		.MAX_PAYLOAD(PAYLOAD_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.packet   (packet_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	packet_scoreboard sb;

	int unsigned in_idle     = 29;
	int unsigned out_idle    = 84;
	int unsigned hold_cycles = 0;
	int unsigned stream_left = 0;
	int unsigned quiet_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random ready, or a long hold-off when asked
	initial begin
		packet_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				packet_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				packet_ch.ready <= ($urandom_range(0, 99) >= out_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready)
				sb.note_frame_byte(frame_ch.data_byte, frame_ch.frame_len,
					frame_ch.payload_type);
			if (packet_ch.valid && packet_ch.ready)
				sb.check_beat(packet_ch.out_byte, packet_ch.packet_end, packet_ch.run_last);
			if ((frame_ch.valid && frame_ch.ready) || (packet_ch.valid && packet_ch.ready))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [BYTE_W-1:0] d, input logic [FLEN_W-1:0] len,
			input logic [PTYPE_W-1:0] pt);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.data_byte    <= d;
		frame_ch.frame_len    <= len;
		frame_ch.payload_type <= pt;
		do @(posedge clk); while (!frame_ch.ready);
		if (stream_left == 0)
			stream_left = (len == 0) ? 1 : len;
		stream_left--;
	endtask

	// mid-frame beats carry noise in the length and type fields
	task automatic random_beats(input int unsigned n);
		logic [FLEN_W-1:0] len;
		repeat (n) begin
			if (stream_left == 0) begin
				if ($urandom_range(0, 99) < 3)
					len = '0;
				else if ($urandom_range(0, 3) == 0)
					len = FLEN_W'($urandom_range(1, 40));
				else
					len = FLEN_W'($urandom_range(1, 6));
				send_beat(BYTE_W'($urandom_range(0, 255)), len,
					PTYPE_W'($urandom_range(0, 127)));
			end else begin
				send_beat(BYTE_W'($urandom_range(0, 255)), FLEN_W'($urandom()),
					PTYPE_W'($urandom_range(0, 127)));
			end
		end
	endtask

	task automatic send_frame(input int unsigned len, input logic [PTYPE_W-1:0] pt);
		while (stream_left != 0)
			send_beat(BYTE_W'($urandom_range(0, 255)), FLEN_W'($urandom()),
				PTYPE_W'($urandom_range(0, 127)));
		send_beat(BYTE_W'($urandom_range(0, 255)), FLEN_W'(len), pt);
		while (stream_left != 0)
			send_beat(BYTE_W'($urandom_range(0, 255)), FLEN_W'($urandom()),
				PTYPE_W'($urandom_range(0, 127)));
	endtask

	task automatic drain();
		@(negedge clk);
		frame_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb                     = new();
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = REG_SOURCE_ID;
		cfg_data               = '0;
		frame_ch.valid         = 1'b0;
		frame_ch.data_byte     = '0;
		frame_ch.frame_len     = '0;
		frame_ch.payload_type  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset values first
		send_beat(8'h00, 24'd1, 7'd0);
		send_beat(8'hFF, 24'd1, 7'h7F);
		send_beat(8'hA5, 24'd0, 7'h55);	// zero length taken as one byte
		send_beat(8'h01, 24'd4, 7'd96);
		send_beat(8'h02, 24'hFFFFFF, 7'h7F);
		send_beat(8'h03, 24'd0, 7'd0);
		send_beat(8'h80, 24'd1, 7'd1);
		send_beat(8'h7F, 24'd2, 7'h2A);
		send_beat(8'hFE, 24'h800000, 7'h40);
		send_frame(5, 7'h11);
		send_frame(3, 7'h7F);
		random_beats(75);
		drain();

		in_idle  = 84;
		out_idle = 29;
		write_reg(REG_SOURCE_ID, 32'hFFFF_FFFF);
		write_reg(REG_TS_STEP, 32'hFFFF_FFFF);
		// a longer frame, then a single-byte one
		send_frame(24, 7'h7F);
		send_frame(1, 7'd0);
		random_beats(75);
		// keep a frame open across the next register change
		if (stream_left == 0)
			send_beat(BYTE_W'($urandom_range(0, 255)), 24'd3, 7'd9);
		drain();

		in_idle  = 0;
		out_idle = 0;
		write_reg(REG_SOURCE_ID, $urandom());
		write_reg(REG_TS_STEP, 32'd0);
		hold_cycles = LONG_HOLD;
		random_beats(80);
		drain();

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
